@@ rtl/core/aabbxf_pkg.sv @@
// Shared types and constants for the bounding box affine transform block.
`timescale 1ns / 1ps

package aabbxf_pkg;

  // Signed Q16.16 coordinate and signed Q2.14 coefficient.
  typedef logic signed [31:0] q16_t;
  typedef logic signed [15:0] coef_t;

  // Packed row of three Q2.14 coefficients, lane 0 in the low bits.
  localparam int ROW_W   = 48;
  localparam int COEF_W  = 16;
  localparam int COORD_W = 32;
  localparam int FRAC_SH = 14;
  localparam int PROD_W  = COORD_W + COEF_W;
  localparam int ACC_W   = 52;
  localparam int RND_W   = ACC_W - FRAC_SH;
  localparam int LANES   = 3;
  localparam int DEPTH   = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  // Reset values: identity matrix, no translation.
  localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;

  typedef struct packed {
    q16_t lo_x;
    q16_t lo_y;
    q16_t lo_z;
    q16_t hi_x;
    q16_t hi_y;
    q16_t hi_z;
  } box_in_t;

  typedef struct packed {
    q16_t out_lo_x;
    q16_t out_lo_y;
    q16_t out_lo_z;
    q16_t out_hi_x;
    q16_t out_hi_y;
    q16_t out_hi_z;
  } box_out_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_x;
    logic [ROW_W-1:0] row_y;
    logic [ROW_W-1:0] row_z;
    q16_t             shift_x;
    q16_t             shift_y;
    q16_t             shift_z;
  } cfg_t;

endpackage

@@ rtl/core/aabb_affine_transform_top.sv @@
// Top level of the bounding box affine transform pipeline.
`timescale 1ns / 1ps

//  channel   handshake              payload
//  input     start / busy           in_box  (box_in_t)
//  result    out_strobe             out_box (box_out_t)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One box enters per cycle; its result comes out with out_strobe after it has
// passed the four pipeline stages: multiply, per-axis extremes, sum, round and
// saturate. busy is never high and cfg_ready is always high.
// Reset is synchronous and clears the stage valid bits and the registers to
// the identity transform. The receiver cannot stall, so nothing is held back.

module aabb_affine_transform_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  aabbxf_pkg::box_in_t               in_box,
  output logic                              out_strobe,
  output aabbxf_pkg::box_out_t              out_box,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aabbxf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aabbxf_pkg::ROW_W-1:0]      cfg_data
);

  localparam int CW = aabbxf_pkg::COEF_W;

  aabbxf_pkg::cfg_t             cfg;
  aabbxf_pkg::q16_t             shift [aabbxf_pkg::LANES];
  aabbxf_pkg::q16_t             lane_lo [aabbxf_pkg::LANES];
  aabbxf_pkg::q16_t             lane_hi [aabbxf_pkg::LANES];
  logic [aabbxf_pkg::DEPTH-1:0] vld_r;
  logic [aabbxf_pkg::DEPTH-1:0] vld_nxt;
  logic                         in_xfer;

  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  aabbxf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  assign shift[0] = cfg.shift_x;
  assign shift[1] = cfg.shift_y;
  assign shift[2] = cfg.shift_z;

  // One datapath lane per output axis, column j of the matrix.
  for (genvar j = 0; j < aabbxf_pkg::LANES; j++) begin : g_lane
    aabbxf_lane u_lane (
      .clk     (clk),
      .box_i   (in_box),
      .coef_x  (cfg.row_x[CW*j +: CW]),
      .coef_y  (cfg.row_y[CW*j +: CW]),
      .coef_z  (cfg.row_z[CW*j +: CW]),
      .shift_i (shift[j]),
      .lo_o    (lane_lo[j]),
      .hi_o    (lane_hi[j])
    );
  end

  // Valid bits travel alongside the lane stages.
  assign vld_nxt = {vld_r[aabbxf_pkg::DEPTH-2:0], in_xfer};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_strobe       = vld_r[aabbxf_pkg::DEPTH-1];
  assign out_box.out_lo_x = lane_lo[0];
  assign out_box.out_lo_y = lane_lo[1];
  assign out_box.out_lo_z = lane_lo[2];
  assign out_box.out_hi_x = lane_hi[0];
  assign out_box.out_hi_y = lane_hi[1];
  assign out_box.out_hi_z = lane_hi[2];

  // Every result traces back to a matching earlier input transfer.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_xfer, aabbxf_pkg::DEPTH))
    else $error("result without a matching input transfer");

  // The minimum over the corners never exceeds the maximum.
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_box.out_lo_x <= out_box.out_hi_x &&
                    out_box.out_lo_y <= out_box.out_hi_y &&
                    out_box.out_lo_z <= out_box.out_hi_z))
    else $error("result box is inverted");

endmodule

@@ rtl/core/aabbxf_cfg_regs.sv @@
// Configuration register file for the matrix rows and translation.
`timescale 1ns / 1ps

module aabbxf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aabbxf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aabbxf_pkg::ROW_W-1:0]       cfg_data,
  output aabbxf_pkg::cfg_t                   cfg_o
);

  aabbxf_pkg::cfg_t cfg_r;
  aabbxf_pkg::cfg_t cfg_nxt;
  logic             wr_en;

  // Writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;
  assign cfg_o     = cfg_r;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_index)
        aabbxf_pkg::REG_ROW_X:   cfg_nxt.row_x   = cfg_data;
        aabbxf_pkg::REG_ROW_Y:   cfg_nxt.row_y   = cfg_data;
        aabbxf_pkg::REG_ROW_Z:   cfg_nxt.row_z   = cfg_data;
        aabbxf_pkg::REG_SHIFT_X: cfg_nxt.shift_x = cfg_data[aabbxf_pkg::COORD_W-1:0];
        aabbxf_pkg::REG_SHIFT_Y: cfg_nxt.shift_y = cfg_data[aabbxf_pkg::COORD_W-1:0];
        aabbxf_pkg::REG_SHIFT_Z: cfg_nxt.shift_z = cfg_data[aabbxf_pkg::COORD_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register file with identity reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_x   <= aabbxf_pkg::ROW_X_RST;
      cfg_r.row_y   <= aabbxf_pkg::ROW_Y_RST;
      cfg_r.row_z   <= aabbxf_pkg::ROW_Z_RST;
      cfg_r.shift_x <= '0;
      cfg_r.shift_y <= '0;
      cfg_r.shift_z <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A shift_x translation write lands in the register on the next cycle.
  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && cfg_index == aabbxf_pkg::REG_SHIFT_X)
      |=> (cfg_r.shift_x == $past(cfg_data[aabbxf_pkg::COORD_W-1:0])))
    else $error("shift_x write not applied");

  // Without a transfer on the write channel the registers hold.
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(cfg_r))
    else $error("configuration changed without a write");

endmodule

@@ rtl/core/aabbxf_lane.sv @@
// One output axis: products, per-axis extremes, sum, rounding and saturation.
`timescale 1ns / 1ps

module aabbxf_lane (
  input  logic                  clk,
  input  aabbxf_pkg::box_in_t   box_i,
  input  aabbxf_pkg::coef_t     coef_x,
  input  aabbxf_pkg::coef_t     coef_y,
  input  aabbxf_pkg::coef_t     coef_z,
  input  aabbxf_pkg::q16_t      shift_i,
  output aabbxf_pkg::q16_t      lo_o,
  output aabbxf_pkg::q16_t      hi_o
);

  localparam int PW = aabbxf_pkg::PROD_W;
  localparam int AW = aabbxf_pkg::ACC_W;
  localparam int RW = aabbxf_pkg::RND_W;
  localparam int CW = aabbxf_pkg::COORD_W;
  localparam int SH = aabbxf_pkg::FRAC_SH;

  // Stage 1: six exact Q18.30 products.
  logic signed [PW-1:0] p_lo_x_r, p_hi_x_r, p_lo_y_r, p_hi_y_r, p_lo_z_r, p_hi_z_r;
  // Stage 2: per-axis smaller and larger product.
  logic signed [PW-1:0] mn_x_r, mx_x_r, mn_y_r, mx_y_r, mn_z_r, mx_z_r;
  // Stage 3: exact sums for the minimum and maximum corner.
  logic signed [AW-1:0] acc_lo_r, acc_hi_r, acc_lo_nxt, acc_hi_nxt;
  logic signed [AW-1:0] t_ext;
  // Stage 4: rounded and saturated results.
  aabbxf_pkg::q16_t     lo_r, hi_r;

  function automatic aabbxf_pkg::q16_t round_sat(input logic signed [AW-1:0] acc);
    logic [AW-1:0] biased;
    logic [RW-1:0] q;
    biased = acc + AW'(1 << (SH - 1));
    q      = biased[AW-1:SH];
    if (q[RW-1:CW-1] == '0 || q[RW-1:CW-1] == '1) begin
      round_sat = q[CW-1:0];
    end else if (q[RW-1]) begin
      round_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    p_lo_x_r <= box_i.lo_x * coef_x;
    p_hi_x_r <= box_i.hi_x * coef_x;
    p_lo_y_r <= box_i.lo_y * coef_y;
    p_hi_y_r <= box_i.hi_y * coef_y;
    p_lo_z_r <= box_i.lo_z * coef_z;
    p_hi_z_r <= box_i.hi_z * coef_z;
  end

  // The sum is separable, so the corner extremes are per-axis extremes.
  always_ff @(posedge clk) begin
    mn_x_r <= (p_lo_x_r < p_hi_x_r) ? p_lo_x_r : p_hi_x_r;
    mx_x_r <= (p_lo_x_r < p_hi_x_r) ? p_hi_x_r : p_lo_x_r;
    mn_y_r <= (p_lo_y_r < p_hi_y_r) ? p_lo_y_r : p_hi_y_r;
    mx_y_r <= (p_lo_y_r < p_hi_y_r) ? p_hi_y_r : p_lo_y_r;
    mn_z_r <= (p_lo_z_r < p_hi_z_r) ? p_lo_z_r : p_hi_z_r;
    mx_z_r <= (p_lo_z_r < p_hi_z_r) ? p_hi_z_r : p_lo_z_r;
  end

  // Translation scaled to Q.30 and added to the three products.
  assign t_ext = {{(AW-CW-SH){shift_i[CW-1]}}, shift_i, {SH{1'b0}}};
  always_comb begin
    acc_lo_nxt = {{(AW-PW){mn_x_r[PW-1]}}, mn_x_r}
               + {{(AW-PW){mn_y_r[PW-1]}}, mn_y_r}
               + {{(AW-PW){mn_z_r[PW-1]}}, mn_z_r} + t_ext;
    acc_hi_nxt = {{(AW-PW){mx_x_r[PW-1]}}, mx_x_r}
               + {{(AW-PW){mx_y_r[PW-1]}}, mx_y_r}
               + {{(AW-PW){mx_z_r[PW-1]}}, mx_z_r} + t_ext;
  end

  always_ff @(posedge clk) begin
    acc_lo_r <= acc_lo_nxt;
    acc_hi_r <= acc_hi_nxt;
  end

  // Rounding and saturation are monotonic, so they follow the min and max.
  always_ff @(posedge clk) begin
    lo_r <= round_sat(acc_lo_r);
    hi_r <= round_sat(acc_hi_r);
  end

  assign lo_o = lo_r;
  assign hi_o = hi_r;

endmodule
